FILE: hdl/lifnu_pkg.sv
// shared types, constants and codes for the lif neuron layer update block
`default_nettype none
package lifnu_pkg;

   // layer size and derived storage geometry
   localparam int NEURONS  = 64;
   localparam int NEURON_W = 6;
   localparam int DEPTH    = (NEURONS < (1 << NEURON_W)) ? NEURONS : (1 << NEURON_W);
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // item kinds
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_STEP  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // reset values of the per-neuron parameters
   localparam logic signed [31:0] THRESHOLD_RESET = 32'sd65536;
   localparam logic [15:0]        DECAY_RESET     = 16'd32768;
   localparam logic [15:0]        COUNT_MAX       = 16'hFFFF;

   typedef struct packed {
      logic [1:0]          mode;
      logic [NEURON_W-1:0] neuron;
      logic signed [31:0]  input_current;
      logic signed [31:0]  threshold;
      logic [15:0]         current_decay;
      logic [15:0]         voltage_decay;
   } req_type;

   typedef struct packed {
      logic               spike;
      logic signed [31:0] voltage;
      logic signed [31:0] trace;
      logic [15:0]        spike_total;
   } rsp_type;

   // control from the sequencer to the neuron store
   typedef struct packed {
      logic              rd_en;
      logic              par_we;
      logic              dyn_we;
      logic              clear_all;
      logic [ADDR_W-1:0] addr;
   } store_cmd_type;

   // registered read data of one neuron
   typedef struct packed {
      logic signed [31:0] voltage;
      logic signed [31:0] trace;
      logic signed [31:0] threshold;
      logic [15:0]        current_decay;
      logic [15:0]        voltage_decay;
   } store_rd_type;

endpackage
`default_nettype wire

FILE: hdl/lifnu_if.sv
// valid/ready channel interfaces for request and response transactions
`default_nettype none
interface lifnu_req_if;
   import lifnu_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lifnu_rsp_if;
   import lifnu_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/lifnu_arith.sv
// shared arithmetic unit: registered q16 fractional multiply and saturating add/subtract
`default_nettype none
module lifnu_arith (
   input  wire logic               clock,
   input  wire logic               mul_en,
   input  wire logic signed [31:0] mul_a,
   input  wire logic        [15:0] mul_f,
   output      logic signed [31:0] prod_q,
   input  wire logic signed [31:0] add_a,
   input  wire logic signed [31:0] add_b,
   input  wire logic               add_sub,
   output      logic signed [31:0] sum
);
   import lifnu_pkg::*;

   logic signed [48:0] product;
   logic signed [32:0] wide_sum;
   logic signed [31:0] prod_ff;

   // signed by unsigned q0.16 product, arithmetic shift gives the floor
   assign product = mul_a * $signed({1'b0, mul_f});

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= product[47:16];
      end
   end

   assign prod_q = prod_ff;

   // 33-bit sum, clamp to the signed 32-bit range
   always_comb begin
      if (add_sub) begin
         wide_sum = {add_a[31], add_a} - {add_b[31], add_b};
      end else begin
         wide_sum = {add_a[31], add_a} + {add_b[31], add_b};
      end
      if (wide_sum[32] != wide_sum[31]) begin
         sum = wide_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sum = wide_sum[31:0];
      end
   end

endmodule
`default_nettype wire

FILE: hdl/lifnu_store.sv
// per-neuron state and parameter memories with valid bits for reset and clear
`default_nettype none
module lifnu_store (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lifnu_pkg::store_cmd_type cmd,
   input  wire logic signed [31:0]       rest_voltage,
   input  wire logic [63:0]              dyn_wdata,
   input  wire logic [63:0]              par_wdata,
   output      lifnu_pkg::store_rd_type  rd
);
   import lifnu_pkg::*;

   logic [63:0]        dyn_mem [DEPTH];
   logic [63:0]        par_mem [DEPTH];
   logic [DEPTH-1:0]   dyn_valid_ff;
   logic [DEPTH-1:0]   dyn_valid_in;
   logic [DEPTH-1:0]   par_valid_ff;
   logic [DEPTH-1:0]   par_valid_in;
   logic signed [31:0] clear_rest_ff;
   logic [63:0]        dyn_q_ff;
   logic [63:0]        par_q_ff;
   logic               dyn_hit_ff;
   logic               par_hit_ff;

   // memory writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.dyn_we) begin
         dyn_mem[cmd.addr] <= dyn_wdata;
      end
      if (cmd.par_we) begin
         par_mem[cmd.addr] <= par_wdata;
      end
      if (cmd.rd_en) begin
         dyn_q_ff   <= dyn_mem[cmd.addr];
         par_q_ff   <= par_mem[cmd.addr];
         dyn_hit_ff <= dyn_valid_ff[cmd.addr];
         par_hit_ff <= par_valid_ff[cmd.addr];
      end
   end

   // valid bits: reset clears both, a clear drops the dynamic ones
   always_comb begin
      dyn_valid_in = dyn_valid_ff;
      par_valid_in = par_valid_ff;
      if (cmd.clear_all) begin
         dyn_valid_in = '0;
      end else if (cmd.dyn_we) begin
         dyn_valid_in[cmd.addr] = 1'b1;
      end
      if (cmd.par_we) begin
         par_valid_in[cmd.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dyn_valid_ff  <= '0;
         par_valid_ff  <= '0;
         clear_rest_ff <= '0;
      end else begin
         dyn_valid_ff <= dyn_valid_in;
         par_valid_ff <= par_valid_in;
         if (cmd.clear_all) begin
            clear_rest_ff <= rest_voltage;
         end
      end
   end

   // entries never written read as their reset or clear values
   always_comb begin
      if (dyn_hit_ff) begin
         rd.voltage = dyn_q_ff[63:32];
         rd.trace   = dyn_q_ff[31:0];
      end else begin
         rd.voltage = clear_rest_ff;
         rd.trace   = '0;
      end
      if (par_hit_ff) begin
         rd.threshold     = par_q_ff[63:32];
         rd.current_decay = par_q_ff[31:16];
         rd.voltage_decay = par_q_ff[15:0];
      end else begin
         rd.threshold     = THRESHOLD_RESET;
         rd.current_decay = DECAY_RESET;
         rd.voltage_decay = DECAY_RESET;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/lif_neuron_layer_update.sv
// top level: sequencer for a layer of current-based leaky integrate-and-fire neurons
//
//   channel  | direction | handshake           | payload
//   req_ch   | in        | valid / ready       | mode, neuron, input_current, threshold, decays
//   rsp_ch   | out       | valid / ready       | spike, voltage, trace, spike_total
//   csr      | in        | csr_we              | csr_wdata = rest_voltage
//
// a step transaction reads the memory on accept, then the shared multiplier and saturating
// adder are used in three passes (read, trace and volt states) before the done state issues
// the result; no new transaction is accepted until the done state returns to idle.
// a load or mode 3 transaction passes through the read and done states,
// a clear goes from idle straight to the done state.
// reset (synchronous) clears the valid bits, so all stores read their reset values at once.
// ready is high only in the idle state; a result held by a stalled sink keeps the next
// transaction in its done state, delaying that result and the accept after it.
`default_nettype none
module lif_neuron_layer_update (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic signed [31:0] csr_wdata,
   lifnu_req_if.sink               req_ch,
   lifnu_rsp_if.source             rsp_ch
);
   import lifnu_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_TRACE = 3'd2;
   localparam logic [2:0] S_VOLT  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [NEURON_W:0] DEPTH_V = (NEURON_W + 1)'(DEPTH);

   logic [2:0]         state_ff;
   logic [2:0]         state_in;
   req_type            item_ff;
   logic signed [31:0] rest_ff;
   logic [15:0]        count_ff;
   logic [15:0]        count_in;
   logic signed [31:0] diff_ff;
   logic signed [31:0] tn_ff;
   logic signed [31:0] vn_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   logic               accept;
   logic               out_free;
   logic               finish;
   logic               idx_ok;
   logic               is_step;
   logic               fire;
   logic signed [31:0] thr_use;
   logic signed [31:0] v_next;
   store_cmd_type      cmd;
   store_rd_type       rd;
   logic               mul_en;
   logic signed [31:0] mul_a;
   logic [15:0]        mul_f;
   logic signed [31:0] prod_q;
   logic signed [31:0] add_a;
   logic signed [31:0] add_b;
   logic               add_sub;
   logic signed [31:0] sum;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign finish       = (state_ff == S_DONE) && out_free;
   assign idx_ok       = ({1'b0, item_ff.neuron} < DEPTH_V);
   assign is_step      = (item_ff.mode == MODE_STEP) && idx_ok;

   // store access: read at accept, write when the result is issued
   always_comb begin
      cmd.rd_en     = accept && (req_ch.data.mode != MODE_CLEAR);
      cmd.addr      = (state_ff == S_IDLE) ? req_ch.data.neuron[ADDR_W-1:0]
                                           : item_ff.neuron[ADDR_W-1:0];
      cmd.par_we    = finish && (item_ff.mode == MODE_LOAD) && idx_ok;
      cmd.dyn_we    = finish && is_step;
      cmd.clear_all = finish && (item_ff.mode == MODE_CLEAR);
   end

   lifnu_store u_store (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .rest_voltage (rest_ff),
      .dyn_wdata    ({v_next, tn_ff}),
      .par_wdata    ({item_ff.threshold, item_ff.current_decay, item_ff.voltage_decay}),
      .rd           (rd)
   );

   // operand selection for the shared unit in each pass
   always_comb begin
      mul_en  = 1'b0;
      mul_a   = rd.trace;
      mul_f   = rd.current_decay;
      add_a   = rd.voltage;
      add_b   = rest_ff;
      add_sub = 1'b1;
      case (state_ff)
         S_READ: begin
            mul_en = 1'b1;
         end
         S_TRACE: begin
            mul_en  = 1'b1;
            mul_a   = diff_ff;
            mul_f   = rd.voltage_decay;
            add_a   = prod_q;
            add_b   = item_ff.input_current;
            add_sub = 1'b0;
         end
         S_VOLT: begin
            add_a   = prod_q;
            add_b   = tn_ff;
            add_sub = 1'b0;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   lifnu_arith u_arith (
      .clock   (clock),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_f   (mul_f),
      .prod_q  (prod_q),
      .add_a   (add_a),
      .add_b   (add_b),
      .add_sub (add_sub),
      .sum     (sum)
   );

   always_ff @(posedge clock) begin
      case (state_ff)
         S_READ:  diff_ff <= sum;
         S_TRACE: tn_ff   <= sum;
         S_VOLT:  vn_ff   <= sum;
         default: ;
      endcase
   end

   // spike decision against the threshold clamped at zero
   assign thr_use = rd.threshold[31] ? 32'sd0 : rd.threshold;
   assign fire    = is_step && (vn_ff >= thr_use);
   assign v_next  = fire ? rest_ff : vn_ff;

   // result and spike counter
   always_comb begin
      count_in    = count_ff;
      rsp_data_in = '0;
      if (item_ff.mode == MODE_CLEAR) begin
         count_in            = '0;
         rsp_data_in.voltage = rest_ff;
      end else if (idx_ok) begin
         if (fire && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + 16'd1;
         end
         rsp_data_in.spike       = fire;
         rsp_data_in.voltage     = is_step ? v_next : rd.voltage;
         rsp_data_in.trace       = is_step ? tn_ff : rd.trace;
         rsp_data_in.spike_total = count_in;
      end else begin
         rsp_data_in.spike_total = count_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_ch.data.mode == MODE_CLEAR) ? S_DONE : S_READ;
            end
         end
         S_READ:  state_in = is_step ? S_TRACE : S_DONE;
         S_TRACE: state_in = S_VOLT;
         S_VOLT:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rest_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            rest_ff <= csr_wdata;
         end
         if (finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // transaction capture and output register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_ch.data;
      end
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // a finished transaction always shows up at the output
   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished transaction did not reach the output");

   // store writes happen only when a result is issued, at most one kind at once
   a_store_write_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.dyn_we || cmd.par_we || cmd.clear_all) |-> (state_ff == S_DONE))
      else $error("store written outside the done state");

   a_store_write_one: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.dyn_we, cmd.par_we, cmd.clear_all}))
      else $error("more than one store write kind at once");

   // the counter only drops on a clear
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !cmd.clear_all |=> (count_ff >= $past(count_ff)))
      else $error("spike counter decreased without a clear");

   // a reported spike is always counted
   a_spike_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.spike) |-> (rsp_data_ff.spike_total != 16'd0))
      else $error("spike reported with zero spike total");

endmodule
`default_nettype wire
